// ===== hdl/drld_pkg.sv =====
// shared types, codes and widths of the data run list decoder
package drld_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int VCN_W   = 63;
    localparam int LCN_W   = 64;
    localparam int LEN_W   = 64;
    localparam int NIB_W   = 4;
    localparam int FIELD_BYTES = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

    // one classified run, terminator or error handed from front to back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic [LCN_W-1:0]  delta;
        logic              sparse;
        logic              done;
    } drld_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } drld_q_status_t;

endpackage

// ===== hdl/drld_if.sv =====
// handshake channels for run-list bytes and decoded runs
interface drld_in_if
    import drld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface drld_out_if
    import drld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VCN_W-1:0]  start_vcn;
    logic signed [LCN_W-1:0] start_lcn;
    logic [LEN_W-1:0]  run_length;
    logic              sparse;
    logic              list_done;

    modport source (output valid, output kind, output start_vcn, output start_lcn,
                    output run_length, output sparse, output list_done, input ready);
    modport sink   (input valid, input kind, input start_vcn, input start_lcn,
                    input run_length, input sparse, input list_done, output ready);
endinterface

// ===== hdl/drld_front.sv =====
// front end: parses header, length and delta bytes into run, terminator and error records
module drld_front
    import drld_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    drld_in_if.sink        run_bytes,
    input  drld_q_status_t q_status,
    output logic           push,
    output drld_rec_t      push_rec
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [NIB_W-1:0] length_bytes_reg, length_bytes_next;
    logic [NIB_W-1:0] delta_bytes_reg, delta_bytes_next;
    logic [NIB_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] length_acc_reg, length_acc_next;
    logic [LCN_W-1:0] delta_acc_reg, delta_acc_next;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic              fin;
    logic [LEN_W-1:0]  la;
    logic [LCN_W-1:0]  da;
    logic [NIB_W-1:0]  np;

    // bytes past the eighth of a field are dropped
    function automatic logic [63:0] insert_byte(input logic [63:0] acc,
                                                input logic [NIB_W-1:0] pos,
                                                input logic [BYTE_W-1:0] val);
        logic [63:0] r;
        r = acc;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            if (pos == NIB_W'(i))
                r[8*i +: 8] = r[8*i +: 8] | val;
        end
        return r;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] d,
                                                input logic [NIB_W-1:0] nbytes,
                                                input logic [BYTE_W-1:0] last);
        logic [63:0] r;
        r = d;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            if (nbytes < NIB_W'(FIELD_BYTES) && last[BYTE_W-1] && NIB_W'(i) >= nbytes)
                r[8*i +: 8] = 8'hFF;
        end
        return r;
    endfunction

    assign run_bytes.ready = !q_status.full;
    assign accept = run_bytes.valid && run_bytes.ready;
    assign b      = run_bytes.data_byte;
    assign fin    = run_bytes.final_byte;
    assign la     = insert_byte(length_acc_reg, pos_reg, b);
    assign da     = insert_byte(delta_acc_reg, pos_reg, b);
    assign np     = pos_reg + 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        length_bytes_next = length_bytes_reg;
        delta_bytes_next  = delta_bytes_reg;
        pos_next          = pos_reg;
        length_acc_next   = length_acc_reg;
        delta_acc_next    = delta_acc_reg;
        push              = 1'b0;
        push_rec          = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (fin)
                    begin
                        phase_next = PH_HEADER;
                        length_bytes_next = '0;
                        delta_bytes_next  = '0;
                        pos_next = '0;
                        length_acc_next = '0;
                        delta_acc_next  = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (b == '0)
                    begin
                        push = 1'b1;
                        push_rec.kind = KIND_END;
                        push_rec.done = 1'b1;
                        phase_next = fin ? PH_HEADER : PH_SKIP;
                    end
                    else if (fin)
                    begin
                        push = 1'b1;
                        push_rec.kind = KIND_ERR;
                        push_rec.done = 1'b1;
                        length_bytes_next = '0;
                        delta_bytes_next  = '0;
                    end
                    else
                    begin
                        length_bytes_next = b[3:0];
                        delta_bytes_next  = b[7:4];
                        pos_next = '0;
                        length_acc_next = '0;
                        delta_acc_next  = '0;
                        phase_next = (b[3:0] != '0) ? PH_LENGTH : PH_DELTA;
                    end
                end
                PH_LENGTH:
                begin
                    length_acc_next = la;
                    pos_next = np;
                    if (np == length_bytes_reg && delta_bytes_reg == '0)
                    begin
                        // length-only run is sparse
                        push = 1'b1;
                        push_rec.kind   = KIND_RUN;
                        push_rec.length = la;
                        push_rec.sparse = 1'b1;
                        push_rec.done   = fin;
                        phase_next = PH_HEADER;
                        pos_next = '0;
                        length_acc_next = '0;
                        delta_acc_next  = '0;
                    end
                    else
                    begin
                        if (np == length_bytes_reg)
                        begin
                            pos_next = '0;
                            phase_next = PH_DELTA;
                        end
                        if (fin)
                        begin
                            push = 1'b1;
                            push_rec.kind = KIND_ERR;
                            push_rec.done = 1'b1;
                            phase_next = PH_HEADER;
                            length_bytes_next = '0;
                            delta_bytes_next  = '0;
                            pos_next = '0;
                            length_acc_next = '0;
                            delta_acc_next  = '0;
                        end
                    end
                end
                default:
                begin
                    delta_acc_next = da;
                    pos_next = np;
                    if (np == delta_bytes_reg)
                    begin
                        push = 1'b1;
                        push_rec.kind   = KIND_RUN;
                        push_rec.length = length_acc_reg;
                        push_rec.delta  = sign_extend(da, delta_bytes_reg, b);
                        push_rec.sparse = (delta_bytes_reg == '0);
                        push_rec.done   = fin;
                        phase_next = PH_HEADER;
                        pos_next = '0;
                        length_acc_next = '0;
                        delta_acc_next  = '0;
                    end
                    else if (fin)
                    begin
                        push = 1'b1;
                        push_rec.kind = KIND_ERR;
                        push_rec.done = 1'b1;
                        phase_next = PH_HEADER;
                        length_bytes_next = '0;
                        delta_bytes_next  = '0;
                        pos_next = '0;
                        length_acc_next = '0;
                        delta_acc_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            length_bytes_reg <= '0;
            delta_bytes_reg  <= '0;
            pos_reg          <= '0;
            length_acc_reg   <= '0;
            delta_acc_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            length_bytes_reg <= length_bytes_next;
            delta_bytes_reg  <= delta_bytes_next;
            pos_reg          <= pos_next;
            length_acc_reg   <= length_acc_next;
            delta_acc_reg    <= delta_acc_next;
        end
    end

endmodule

// ===== hdl/drld_queue.sv =====
// short record queue between parser and cluster arithmetic
module drld_queue
    import drld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  drld_rec_t      push_rec,
    input  logic           pop,
    output drld_rec_t      pop_rec,
    output drld_q_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    drld_rec_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_rec = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/drld_back.sv =====
// back end: cluster arithmetic and the output register
module drld_back
    import drld_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  drld_rec_t      pop_rec,
    input  drld_q_status_t q_status,
    output logic           pop,
    drld_out_if.source     runs
);

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [VCN_W-1:0]  vcn_reg, vcn_next;
    logic [LCN_W-1:0]  lcn_reg, lcn_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              sparse_reg, sparse_next;
    logic              done_reg, done_next;
    logic [LCN_W-1:0]  base_lcn_reg, base_lcn_next;
    logic [VCN_W-1:0]  next_vcn_reg, next_vcn_next;
    logic [LCN_W-1:0]  lcn_sum;

    assign pop     = !q_status.empty && (!valid_reg || runs.ready);
    assign lcn_sum = base_lcn_reg + pop_rec.delta;

    always_comb
    begin
        kind_next     = pop_rec.kind;
        vcn_next      = '0;
        lcn_next      = '0;
        len_next      = '0;
        sparse_next   = 1'b0;
        done_next     = pop_rec.done;
        base_lcn_next = base_lcn_reg;
        next_vcn_next = next_vcn_reg;
        case (pop_rec.kind)
            KIND_RUN:
            begin
                vcn_next    = next_vcn_reg;
                len_next    = pop_rec.length;
                sparse_next = pop_rec.sparse;
                if (pop_rec.sparse)
                    lcn_next = '1;
                else
                begin
                    lcn_next      = lcn_sum;
                    base_lcn_next = lcn_sum;
                end
                next_vcn_next = next_vcn_reg + pop_rec.length[VCN_W-1:0];
            end
            KIND_END:
                vcn_next = next_vcn_reg;
            default:
                ;
        endcase
        // a finished list starts the cluster counts over
        if (pop_rec.done)
        begin
            base_lcn_next = '0;
            next_vcn_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= kind_next;
            vcn_reg    <= vcn_next;
            lcn_reg    <= lcn_next;
            len_reg    <= len_next;
            sparse_reg <= sparse_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            base_lcn_reg <= '0;
            next_vcn_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg    <= 1'b1;
                base_lcn_reg <= base_lcn_next;
                next_vcn_reg <= next_vcn_next;
            end
            else if (runs.ready)
                valid_reg <= 1'b0;
        end
    end

    assign runs.valid      = valid_reg;
    assign runs.kind       = kind_reg;
    assign runs.start_vcn  = vcn_reg;
    assign runs.start_lcn  = lcn_reg;
    assign runs.run_length = len_reg;
    assign runs.sparse     = sparse_reg;
    assign runs.list_done  = done_reg;

endmodule

// ===== hdl/data_run_list_decoder_unit.sv =====
// top level of the data run list decoder
// usage:
//   run_bytes takes the encoded run list one byte per item, with final_byte
//   set on the last byte of the buffer; runs gives one item per decoded run,
//   per terminator (kind end) and per buffer that ends inside a run (kind error)
//   throughput: one byte per cycle while run_bytes.ready is high; every byte takes one pass through the
//   parser, and each run costs at most one 64-bit add in the back end
//   a result passes from the byte that completes it into the record queue,
//   then into the output register
//   a stalled receiver holds the output register; the queue keeps taking
//   records until it holds DEPTH of them, then run_bytes.ready drops
//   reset clears the parser to expect a header, empties the queue, clears the
//   output valid and sets the running logical and virtual clusters to zero
//   bytes after a terminator give no result until the final byte of the buffer
module data_run_list_decoder_unit
    import drld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    drld_in_if.sink    run_bytes,
    drld_out_if.source runs
);

    logic           push, pop;
    drld_rec_t      push_rec, pop_rec;
    drld_q_status_t q_status;

    drld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .run_bytes(run_bytes),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    drld_queue #(.DEPTH(DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .pop_rec (pop_rec),
        .q_status(q_status)
    );

    drld_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_rec (pop_rec),
        .q_status(q_status),
        .pop     (pop),
        .runs    (runs)
    );

    // terminators and errors always close the list
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid && runs.kind != KIND_RUN |-> runs.list_done)
        else $error("non-run result without list_done");

    a_sparse: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid && runs.sparse |-> runs.start_lcn == '1 && runs.kind == KIND_RUN)
        else $error("sparse run without lcn of -1");

    a_nolen: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid && runs.kind != KIND_RUN |-> runs.run_length == '0 && !runs.sparse)
        else $error("non-run result carries a length");

    // a record popped into the output is shown in the next cycle
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> runs.valid)
        else $error("popped record not presented");

endmodule
